// ===== design/bcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int TIME_W    = 32;
  localparam int BTN_W     = 3;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    EV_PRESSED  = 3'd0,
    EV_DOUBLE   = 3'd1,
    EV_RELEASED = 3'd2,
    EV_SHORT    = 3'd3,
    EV_LONG     = 3'd4
  } bcc_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESSED_LEVEL = 2'd0,
    REG_DC_WINDOW     = 2'd1,
    REG_SHORT_THR     = 2'd2,
    REG_LONG_THR      = 2'd3
  } bcc_reg_t;

  localparam logic              RST_PRESSED_LEVEL = 1'b0;
  localparam logic [TIME_W-1:0] RST_DC_WINDOW     = 32'd300;
  localparam logic [TIME_W-1:0] RST_SHORT_THR     = 32'd500;
  localparam logic [TIME_W-1:0] RST_LONG_THR      = 32'd3000;

  typedef struct packed {
    logic              pressed_level;
    logic [TIME_W-1:0] dc_window;
    logic [TIME_W-1:0] short_thr;
    logic [TIME_W-1:0] long_thr;
  } bcc_cfg_t;

  typedef struct packed {
    logic              is_pressed;
    logic [TIME_W-1:0] press_start;
    logic [TIME_W-1:0] first_click_start;
    logic              awaiting_second;
  } bcc_state_t;

  typedef struct packed {
    logic [BTN_W-1:0]  button;
    bcc_code_t         code;
    logic [TIME_W-1:0] duration;
    logic              last;
  } bcc_result_t;

endpackage

// ===== design/bcc_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_classify
// Per-event classification: next button state and up to two result records.
// ----------------------------------------------------------------------------
module bcc_classify (
  input  bcc_pkg::bcc_cfg_t                  cfg,
  input  logic [bcc_pkg::BTN_W-1:0]          button,
  input  logic                               pin_level,
  input  logic [bcc_pkg::TIME_W-1:0]         now_ms,
  input  bcc_pkg::bcc_state_t                st_cur,
  output bcc_pkg::bcc_state_t                st_nxt,
  output bcc_pkg::bcc_result_t               res0,
  output bcc_pkg::bcc_result_t               res1,
  output logic [1:0]                         res_cnt
);
  import bcc_pkg::*;

  logic              lvl_press;
  logic [TIME_W-1:0] gap;
  logic [TIME_W-1:0] gap_after;
  logic [TIME_W-1:0] dur;
  bcc_state_t        st_mid;

  assign lvl_press = (pin_level == cfg.pressed_level);
  assign gap       = now_ms - st_cur.first_click_start;
  assign dur       = now_ms - st_cur.press_start;

  always_comb begin
    st_mid  = st_cur;
    res0    = '{button: button, code: EV_PRESSED, duration: '0, last: 1'b1};
    res1    = '{button: button, code: EV_PRESSED, duration: '0, last: 1'b1};
    res_cnt = 2'd0;
    if (lvl_press && !st_cur.is_pressed) begin
      st_mid.is_pressed  = 1'b1;
      st_mid.press_start = now_ms;
      if (st_cur.awaiting_second && (gap <= cfg.dc_window)) begin
        st_mid.awaiting_second = 1'b0;
        res0.code = EV_DOUBLE;
        res0.last = 1'b0;
        res1.code = EV_PRESSED;
        res_cnt   = 2'd2;
      end else begin
        st_mid.first_click_start = now_ms;
        st_mid.awaiting_second   = 1'b1;
        res0.code = EV_PRESSED;
        res_cnt   = 2'd1;
      end
    end else if (!lvl_press && st_cur.is_pressed) begin
      st_mid.is_pressed = 1'b0;
      res0.code     = EV_RELEASED;
      res0.duration = dur;
      res1.duration = dur;
      if (dur < cfg.short_thr) begin
        res0.last = 1'b0;
        res1.code = EV_SHORT;
        res_cnt   = 2'd2;
      end else if (dur < cfg.long_thr) begin
        res0.last = 1'b0;
        res1.code = EV_LONG;
        res_cnt   = 2'd2;
      end else begin
        res_cnt = 2'd1;
      end
    end
  end

  // window expiry
  assign gap_after = now_ms - st_mid.first_click_start;

  always_comb begin
    st_nxt = st_mid;
    if (st_mid.awaiting_second && (gap_after > cfg.dc_window)) begin
      st_nxt.awaiting_second = 1'b0;
    end
  end

endmodule

// ===== design/button_click_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier_core
// Classifies button level-change events into press, release, double-click,
// short-press and long-press events.
// ----------------------------------------------------------------------------
// An accepted event is held in an input register and classified into zero,
// one or two results once the result buffer has room; the results wait in
// the two-entry result buffer while the next event is already taken. The
// output port delivers one result per cycle while out_stall is low, and the
// next event moves into the buffer once it is empty or its last result leaves.
// Events for a button index at or above NUM_BUTTONS give nothing and leave
// all state alone. Configuration writes are always ready and take effect at
// once; write them only while idle.
module button_click_classifier_core #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bcc_pkg::BTN_W-1:0]          in_button_index,
  input  logic                               in_pin_level,
  input  logic [bcc_pkg::TIME_W-1:0]         in_now_ms,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bcc_pkg::BTN_W-1:0]          out_event_button,
  output logic [2:0]                         out_event_code,
  output logic [bcc_pkg::TIME_W-1:0]         out_duration_ms,
  output logic                               out_last,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcc_pkg::TIME_W-1:0]         cfg_data
);
  import bcc_pkg::*;

  localparam int MAX_IDX = 1 << BTN_W;
  localparam int DEPTH   = (NUM_BUTTONS < MAX_IDX) ? NUM_BUTTONS : MAX_IDX;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  bcc_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressed_level <= RST_PRESSED_LEVEL;
      cfg_r.dc_window     <= RST_DC_WINDOW;
      cfg_r.short_thr     <= RST_SHORT_THR;
      cfg_r.long_thr      <= RST_LONG_THR;
    end else if (cfg_valid && cfg_ready) begin
      case (bcc_reg_t'(cfg_index))
        REG_PRESSED_LEVEL: cfg_r.pressed_level <= cfg_data[0];
        REG_DC_WINDOW:     cfg_r.dc_window     <= cfg_data;
        REG_SHORT_THR:     cfg_r.short_thr     <= cfg_data;
        REG_LONG_THR:      cfg_r.long_thr      <= cfg_data;
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  // input register
  logic              item_vld_r;
  logic [BTN_W-1:0]  item_btn_r;
  logic              item_lvl_r;
  logic [TIME_W-1:0] item_now_r;

  logic       in_accept;
  logic       move;
  logic       pop;
  logic [1:0] res_cnt_r;
  logic [1:0] res_cnt_nxt;

  assign in_accept = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign move      = item_vld_r && ((res_cnt_r == 2'd0) || ((res_cnt_r == 2'd1) && pop));
  assign in_stall  = item_vld_r && !move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_accept) begin
      item_vld_r <= 1'b1;
    end else if (move) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_btn_r <= in_button_index;
      item_lvl_r <= in_pin_level;
      item_now_r <= in_now_ms;
    end
  end

  // per-button state
  bcc_state_t st_r [DEPTH];
  bcc_state_t st_cur;
  bcc_state_t st_nxt;
  logic       btn_ok;
  logic [IDX_W-1:0] idx;

  assign btn_ok = (32'(item_btn_r) < NUM_BUTTONS);
  assign idx    = item_btn_r[IDX_W-1:0];
  assign st_cur = btn_ok ? st_r[idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        st_r[i] <= '0;
      end
    end else if (move && btn_ok) begin
      st_r[idx] <= st_nxt;
    end
  end

  bcc_result_t new0;
  bcc_result_t new1;
  logic [1:0]  new_cnt;

  bcc_classify u_classify (
    .cfg       (cfg_r),
    .button    (item_btn_r),
    .pin_level (item_lvl_r),
    .now_ms    (item_now_r),
    .st_cur    (st_cur),
    .st_nxt    (st_nxt),
    .res0      (new0),
    .res1      (new1),
    .res_cnt   (new_cnt)
  );

  // result buffer
  bcc_result_t res_r [2];

  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (move) begin
      res_cnt_nxt = btn_ok ? new_cnt : 2'd0;
    end else if (pop) begin
      res_cnt_nxt = res_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= 2'd0;
    end else begin
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_r[0] <= new0;
      res_r[1] <= new1;
    end else if (pop) begin
      res_r[0] <= res_r[1];
    end
  end

  assign out_valid        = (res_cnt_r != 2'd0);
  assign out_event_button = res_r[0].button;
  assign out_event_code   = res_r[0].code;
  assign out_duration_ms  = res_r[0].duration;
  assign out_last         = res_r[0].last;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_partner_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (res_cnt_r == 2'd2))
    else $error("non-final result without its partner");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !item_vld_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_move_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (move && btn_ok && (new_cnt == 2'd0)) |=> (res_cnt_r == 2'd0))
    else $error("result buffer not empty after silent event");
`endif

endmodule
